// File: sv/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int FUNC_W     = 3;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 5;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_SEARCH    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic ld_op;
    logic do_exec;
    logic cap_item;
    logic scan;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic is_search;
    logic empty;
    logic match;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/bdq_ctrl.sv
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld_op = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.do_exec = 1'b1;
        if (stat.is_remove && !stat.empty) begin
          state_nxt = S_RDWAIT;
        end else if (stat.is_search && !stat.empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RDWAIT: begin
        cmd.cap_item = 1'b1;
        state_nxt    = S_OUT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.match || stat.last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sv/bdq_datapath.sv
module bdq_datapath
  import bdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DATA_W-1:0]     in_tdata,   // value
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // item, position, zero pad
  output logic [STAT_W-1:0]     out_tuser   // status
);

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) sum = sum - (IDX_W+1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] value_r;
  logic [IDX_W-1:0]  front_r;
  logic [CNT_W-1:0]  occ_r;
  logic [IDX_W-1:0]  idx_r;

  logic [STAT_W-1:0] res_status_r;
  logic [DATA_W-1:0] res_item_r;
  logic [POS_W-1:0]  res_pos_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [DATA_W-1:0] out_item_r;
  logic [POS_W-1:0]  out_pos_r;

  logic             empty, full, is_insert, is_remove, is_search, wr_en;
  logic [IDX_W-1:0] front_dec, front_inc, back_slot, tail_slot;
  logic [IDX_W-1:0] wr_addr, rd_addr, idx_nxt;
  logic [CNT_W-1:0] idx_cnt;

  assign empty     = (occ_r == '0);
  assign full      = (occ_r == CNT_W'(DEPTH));
  assign is_insert = (func_r == OP_INS_FRONT) || (func_r == OP_INS_BACK);
  assign is_remove = (func_r == OP_REM_FRONT) || (func_r == OP_REM_BACK);
  assign is_search = (func_r == OP_SEARCH);

  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  // only used while occupancy is below DEPTH, so it fits the slot width
  assign back_slot = slot_of(front_r, occ_r[IDX_W-1:0]);
  assign tail_slot = slot_of(front_r, IDX_W'(occ_r - 1'b1));
  assign idx_nxt   = idx_r + 1'b1;
  assign idx_cnt   = CNT_W'(idx_r) + CNT_W'(1);

  assign wr_en   = cmd.do_exec && is_insert && !full;
  assign wr_addr = (func_r == OP_INS_FRONT) ? front_dec : back_slot;

  // scan reads one entry ahead of the compare
  always_comb begin
    if (cmd.scan) begin
      rd_addr = slot_of(front_r, idx_nxt);
    end else if (func_r == OP_REM_BACK) begin
      rd_addr = tail_slot;
    end else begin
      rd_addr = front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= value_r;
    rd_data_r <= mem[rd_addr];
  end

  assign stat.is_remove = is_remove;
  assign stat.is_search = is_search;
  assign stat.empty     = empty;
  assign stat.match     = (rd_data_r == value_r);
  assign stat.last      = (idx_cnt == occ_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_exec) begin
        case (func_r)
          OP_INS_FRONT: begin
            if (!full) begin
              front_r <= front_dec;
              occ_r   <= occ_r + 1'b1;
            end
          end
          OP_INS_BACK: begin
            if (!full) occ_r <= occ_r + 1'b1;
          end
          OP_REM_FRONT: begin
            if (!empty) begin
              front_r <= front_inc;
              occ_r   <= occ_r - 1'b1;
            end
          end
          OP_REM_BACK: begin
            if (!empty) occ_r <= occ_r - 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_op) begin
      func_r  <= in_tuser;
      value_r <= in_tdata;
    end
    if (cmd.do_exec) begin
      res_status_r <= ST_OK;
      res_item_r   <= '0;
      res_pos_r    <= '0;
      idx_r        <= '0;
      if (is_insert && full) res_status_r <= ST_FULL;
      if ((is_remove || is_search) && empty) res_status_r <= ST_EMPTY;
    end
    if (cmd.cap_item) res_item_r <= rd_data_r;
    if (cmd.scan) begin
      idx_r <= idx_nxt;
      if (stat.match) begin
        res_status_r <= ST_OK;
        res_item_r   <= value_r;
        res_pos_r    <= POS_W'(idx_cnt);
      end else begin
        res_status_r <= ST_MISS;
      end
    end
    if (cmd.ld_out) begin
      out_status_r <= res_status_r;
      out_item_r   <= res_item_r;
      out_pos_r    <= res_pos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_DATA_W - DATA_W - POS_W)'(0), out_pos_r, out_item_r};

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= IDX_W'(DEPTH - 1))
    else $error("front index out of range");

  a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.do_exec |=> $stable(occ_r))
    else $error("occupancy changed outside execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending beat");

endmodule

// File: sv/bounded_deque_with_search_top.sv
// Bounded deque of up to DEPTH signed 32-bit values held in a ring memory with one write
// port and one registered read port, with front/back insert, front/back remove and a
// front-to-back search. One request is in flight at a time and each gives one result beat.
// From accept to result register an insert, an unused func code or a request on an empty
// deque passes S_EXEC and S_OUT, a removal S_EXEC, S_RDWAIT and S_OUT, and a search S_EXEC,
// S_SCAN once per entry up to the 1-based match position (occupancy on a miss) and S_OUT;
// the scan reads one entry per cycle through the memory's registered read port, and the next
// request is accepted in the cycle after the result is registered, even if out_tready is low.
// in_tuser carries func, out_tuser the status code.
module bounded_deque_with_search_top
  import bdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [31:0] value
  input  logic [FUNC_W-1:0]     in_tuser,   // [2:0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] item, [36:32] position, zero pad
  output logic [STAT_W-1:0]     out_tuser   // [1:0] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
